>>> hdl/dia_pkg.sv
// ----------------------------------------------------------------------------
// dia_pkg
// Shared widths, codes and controller/datapath interface types for the
// descriptor index allocator.
// ----------------------------------------------------------------------------
package dia_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int COUNT_W   = SLOT_W + 1;
    localparam int CAP_W     = 11;
    localparam int STRIDE_W  = 9;
    localparam int ADDR_W    = 64;
    localparam int PROD_W    = SLOT_W + STRIDE_W;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_HELD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE = 2'd3;

    localparam logic [CAP_W-1:0]    CAPACITY_RESET = CAP_W'(MAX_SLOTS);
    localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 9'd32;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic take_fresh;
        logic pop;
        logic latch_pop;
        logic empty;
        logic read_map;
        logic check;
        logic multiply;
        logic load_out;
    } dia_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic kind;
        logic fresh_avail;
        logic fifo_nonempty;
        logic out_free;
    } dia_sts_t;

endpackage

>>> hdl/dia_ctrl.sv
// ----------------------------------------------------------------------------
// dia_ctrl
// Sequencer for one request at a time: lookup, FIFO or bitmap access,
// address multiply, and hand-off to the output register.
// ----------------------------------------------------------------------------
module dia_ctrl
    import dia_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dia_sts_t sts,
    output dia_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_POP,
        S_CHECK,
        S_MUL,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (sts.kind == KIND_RELEASE) begin
                    cmd.read_map = 1'b1;
                    state_next   = S_CHECK;
                end else if (sts.fresh_avail) begin
                    cmd.take_fresh = 1'b1;
                    state_next     = S_MUL;
                end else if (sts.fifo_nonempty) begin
                    cmd.pop    = 1'b1;
                    state_next = S_POP;
                end else begin
                    cmd.empty  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_POP: begin
                cmd.latch_pop = 1'b1;
                state_next    = S_MUL;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.multiply = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register is free
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/dia_datapath.sv
// ----------------------------------------------------------------------------
// dia_datapath
// Configuration registers, fresh-slot counter, recycled-slot FIFO, in-use
// bitmap, address arithmetic and the output register.
// ----------------------------------------------------------------------------
module dia_datapath
    import dia_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 s_kind,
    input  logic [SLOT_W-1:0]    s_slot,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [SLOT_W-1:0]    m_granted_slot,
    output logic [ADDR_W-1:0]    m_cpu_address,
    output logic [ADDR_W-1:0]    m_gpu_address,
    input  dia_cmd_t             cmd,
    output dia_sts_t             sts
);

    logic [CAP_W-1:0]    capacity_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [ADDR_W-1:0]   cpu_base_reg;
    logic [ADDR_W-1:0]   gpu_base_reg;

    logic [SLOT_W-1:0]   head_reg, tail_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  fresh_reg;
    logic                m_valid_reg;

    logic                kind_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   got_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                addr_en_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SLOT_W-1:0]   fifo_q_reg;
    logic                map_q_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [SLOT_W-1:0]   m_slot_reg;
    logic [ADDR_W-1:0]   m_cpu_reg, m_gpu_reg;

    logic [SLOT_W-1:0]   fifo_mem [MAX_SLOTS];
    logic                map_mem  [MAX_SLOTS];

    logic [COUNT_W-1:0]  eff_cap;
    logic                held;
    logic                push;
    logic                map_we;
    logic [SLOT_W-1:0]   map_waddr;
    logic                map_wdata;
    logic [ADDR_W-1:0]   prod_ext;

    function automatic logic [SLOT_W-1:0] advance(input logic [SLOT_W-1:0] pos);
        logic [SLOT_W-1:0] last;
        last = SLOT_W'(MAX_SLOTS - 1);
        return (pos == last) ? '0 : pos + 1'b1;
    endfunction

    assign cfg_ready = 1'b1;

    assign eff_cap = (capacity_reg > CAP_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                         : COUNT_W'(capacity_reg);

    // bitmap entries at or above the fresh counter were never written: not held
    assign held = map_q_reg && (COUNT_W'(slot_reg) < fresh_reg)
                  && (count_reg < COUNT_W'(MAX_SLOTS));
    assign push = cmd.check && held;

    assign sts.kind          = kind_reg;
    assign sts.fresh_avail   = (fresh_reg < eff_cap);
    assign sts.fifo_nonempty = (count_reg != '0);
    assign sts.out_free      = !m_valid_reg || m_ready;

    always_comb begin
        map_we    = 1'b0;
        map_waddr = slot_reg;
        map_wdata = 1'b0;
        if (cmd.take_fresh) begin
            map_we    = 1'b1;
            map_waddr = fresh_reg[SLOT_W-1:0];
            map_wdata = 1'b1;
        end else if (cmd.latch_pop) begin
            map_we    = 1'b1;
            map_waddr = fifo_q_reg;
            map_wdata = 1'b1;
        end else if (push) begin
            map_we    = 1'b1;
            map_waddr = slot_reg;
            map_wdata = 1'b0;
        end
    end

    assign prod_ext = ADDR_W'(prod_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            stride_reg   <= STRIDE_RESET;
            cpu_base_reg <= '0;
            gpu_base_reg <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            fresh_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_CAPACITY: capacity_reg <= cfg_data[CAP_W-1:0];
                    CFG_STRIDE:   stride_reg   <= cfg_data[STRIDE_W-1:0];
                    CFG_CPU_BASE: cpu_base_reg <= cfg_data;
                    CFG_GPU_BASE: gpu_base_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.take_fresh) begin
                fresh_reg <= fresh_reg + 1'b1;
            end
            if (cmd.pop) begin
                head_reg  <= advance(head_reg);
                count_reg <= count_reg - 1'b1;
            end
            if (push) begin
                tail_reg  <= advance(tail_reg);
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[tail_reg] <= slot_reg;
        end
        if (cmd.pop) begin
            fifo_q_reg <= fifo_mem[head_reg];
        end
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (cmd.read_map) begin
            map_q_reg <= map_mem[slot_reg];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_kind;
            slot_reg <= s_slot;
        end
        if (cmd.take_fresh) begin
            got_reg        <= fresh_reg[SLOT_W-1:0];
            res_status_reg <= STATUS_OK;
            addr_en_reg    <= 1'b1;
        end
        if (cmd.latch_pop) begin
            got_reg        <= fifo_q_reg;
            res_status_reg <= STATUS_OK;
            addr_en_reg    <= 1'b1;
        end
        if (cmd.empty) begin
            got_reg        <= '0;
            res_status_reg <= STATUS_EMPTY;
            addr_en_reg    <= 1'b0;
        end
        if (cmd.check) begin
            got_reg        <= slot_reg;
            res_status_reg <= held ? STATUS_OK : STATUS_NOT_HELD;
            addr_en_reg    <= 1'b0;
        end
        if (cmd.multiply) begin
            prod_reg <= PROD_W'(got_reg * stride_reg);
        end
        if (cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= got_reg;
            m_cpu_reg    <= addr_en_reg ? cpu_base_reg + prod_ext : '0;
            m_gpu_reg    <= addr_en_reg ? gpu_base_reg + prod_ext : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_granted_slot = m_slot_reg;
    assign m_cpu_address  = m_cpu_reg;
    assign m_gpu_address  = m_gpu_reg;

endmodule

>>> hdl/descriptor_index_allocator.sv
// Flow: a fresh allocate or an empty result steps through lookup, multiply and
// finish; a reissue from the FIFO adds a pop state and a release a check state.
// The controller sequences one request at a time: a new request is not taken until
// the finished result has been loaded into the output register, which waits on m_ready.
// Reset: synchronous, active low; requests are taken in the first cycle after
// reset, with no clearing pass (the fresh counter marks written bitmap entries).
// ----------------------------------------------------------------------------
// descriptor_index_allocator
// Hands out never-issued descriptor slot indices first, then recycled ones in FIFO order, takes them back, and
// returns the CPU and GPU addresses of each granted slot.
// ----------------------------------------------------------------------------
module descriptor_index_allocator
    import dia_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [SLOT_W-1:0]    s_slot,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [SLOT_W-1:0]    m_granted_slot,
    output logic [ADDR_W-1:0]    m_cpu_address,
    output logic [ADDR_W-1:0]    m_gpu_address
);

    dia_cmd_t cmd;
    dia_sts_t sts;

    dia_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dia_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_kind         (s_kind),
        .s_slot         (s_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_slot (m_granted_slot),
        .m_cpu_address  (m_cpu_address),
        .m_gpu_address  (m_gpu_address),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

>>> bench/descriptor_index_allocator_tb.sv
// ----------------------------------------------------------------------------
// descriptor_index_allocator_tb
// Self-checking bench for the descriptor slot allocator: a scripted opening
// covers reset order, exhaustion, bad releases, address wrap and odd register
// values, then random request mixes run under several table settings with
// bursty input and a stalling result sink, all checked against a local model.
// ----------------------------------------------------------------------------
module descriptor_index_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dia_pkg::*;

    localparam int LIMIT_NS = 3_000_000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   cpu;
        logic [ADDR_W-1:0]   gpu;
    } slot_result_t;

    typedef enum logic {ROW_REQUEST, ROW_WRITE} row_op_t;

    typedef struct packed {
        row_op_t              op;
        logic                 kind;
        logic [SLOT_W-1:0]    slot;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [ADDR_W-1:0]    reg_data;
        bit                   typed;
        slot_result_t         want;
    } stim_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CAPACITY;
    logic [ADDR_W-1:0]    cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_kind    = KIND_ALLOC;
    logic [SLOT_W-1:0]    s_slot    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [SLOT_W-1:0]    m_granted_slot;
    logic [ADDR_W-1:0]    m_cpu_address;
    logic [ADDR_W-1:0]    m_gpu_address;

    descriptor_index_allocator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_slot         (s_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_slot (m_granted_slot),
        .m_cpu_address  (m_cpu_address),
        .m_gpu_address  (m_gpu_address)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Allocator model state
    logic [CAP_W-1:0]    cap_reg      = CAPACITY_RESET;
    logic [STRIDE_W-1:0] stride_reg   = STRIDE_RESET;
    logic [ADDR_W-1:0]   cpu_base_reg = '0;
    logic [ADDR_W-1:0]   gpu_base_reg = '0;
    logic [SLOT_W-1:0]   recycle_q [MAX_SLOTS];
    bit                  in_use    [MAX_SLOTS];
    int                  rd_pos    = 0;
    int                  wr_pos    = 0;
    int                  queued    = 0;
    int                  fresh_ptr = 0;

    slot_result_t pending_results[$];
    stim_row_t    script[$];

    int mismatches = 0;
    int grants     = 0;
    int exhausted  = 0;
    int releases   = 0;
    int rejected   = 0;
    int reg_writes = 0;

    function automatic slot_result_t allocate_or_release(logic kind, logic [SLOT_W-1:0] slot);
        slot_result_t r;
        int eff_cap;
        int got;
        r = '0;
        eff_cap = (cap_reg > MAX_SLOTS) ? MAX_SLOTS : int'(cap_reg);
        if (kind == KIND_ALLOC) begin
            // never-issued slots first, then the oldest recycled one
            if (fresh_ptr < eff_cap) begin
                got = fresh_ptr;
                fresh_ptr++;
            end else if (queued != 0) begin
                got = recycle_q[rd_pos];
                rd_pos = (rd_pos + 1) % MAX_SLOTS;
                queued--;
            end else begin
                r.status = STATUS_EMPTY;
                return r;
            end
            in_use[got] = 1'b1;
            r.status = STATUS_OK;
            r.slot   = SLOT_W'(got);
            r.cpu    = cpu_base_reg + ADDR_W'(got) * ADDR_W'(stride_reg);
            r.gpu    = gpu_base_reg + ADDR_W'(got) * ADDR_W'(stride_reg);
        end else begin
            r.slot = slot;
            if (!in_use[slot] || queued >= MAX_SLOTS) begin
                r.status = STATUS_NOT_HELD;
            end else begin
                in_use[slot] = 1'b0;
                recycle_q[wr_pos] = slot;
                wr_pos = (wr_pos + 1) % MAX_SLOTS;
                queued++;
                r.status = STATUS_OK;
            end
        end
        return r;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        case (idx)
            CFG_CAPACITY: cap_reg      = data[CAP_W-1:0];
            CFG_STRIDE:   stride_reg   = data[STRIDE_W-1:0];
            CFG_CPU_BASE: cpu_base_reg = data;
            CFG_GPU_BASE: gpu_base_reg = data;
            default: ;
        endcase
    endfunction

    function automatic int pick_held_slot();
        int owned[$];
        for (int i = 0; i < MAX_SLOTS; i++)
            if (in_use[i]) owned.push_back(i);
        if (owned.size() == 0) return -1;
        return owned[$urandom_range(owned.size() - 1)];
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.op       = ROW_WRITE;
        row.reg_idx  = idx;
        row.reg_data = data;
        script.push_back(row);
    endfunction

    function automatic void add_request(logic kind, logic [SLOT_W-1:0] slot);
        stim_row_t row;
        row = '0;
        row.op   = ROW_REQUEST;
        row.kind = kind;
        row.slot = slot;
        script.push_back(row);
    endfunction

    function automatic void add_typed(logic kind, logic [SLOT_W-1:0] slot,
                                      logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] gslot,
                                      logic [ADDR_W-1:0] cpu, logic [ADDR_W-1:0] gpu);
        stim_row_t row;
        row = '0;
        row.op          = ROW_REQUEST;
        row.kind        = kind;
        row.slot        = slot;
        row.typed       = 1'b1;
        row.want.status = status;
        row.want.slot   = gslot;
        row.want.cpu    = cpu;
        row.want.gpu    = gpu;
        script.push_back(row);
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles != 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic send_request(input logic kind, input logic [SLOT_W-1:0] slot,
                                input bit typed, input slot_result_t typed_result);
        slot_result_t predicted;
        // a register write may have left cfg_valid up; drop it here
        cfg_valid <= 1'b0;
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_slot    <= slot;
        do @(posedge aclk); while (!s_ready);
        predicted = allocate_or_release(kind, slot);
        if (typed) predicted = typed_result;
        case (predicted.status)
            STATUS_OK:    if (kind == KIND_ALLOC) grants++; else releases++;
            STATUS_EMPTY: exhausted++;
            default:      rejected++;
        endcase
        pending_results.push_back(predicted);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(idx, data);
        reg_writes++;
    endtask

    task automatic write_phase(input logic [CAP_W-1:0] cap, input logic [STRIDE_W-1:0] stride,
                               input logic [ADDR_W-1:0] cpu, input logic [ADDR_W-1:0] gpu);
        logic [ADDR_W-1:0] noise;
        // junk above the field width must be ignored
        noise = {$urandom, $urandom};
        write_register(CFG_CAPACITY, {noise[ADDR_W-1:CAP_W], cap});
        noise = {$urandom, $urandom};
        write_register(CFG_STRIDE, {noise[ADDR_W-1:STRIDE_W], stride});
        write_register(CFG_CPU_BASE, cpu);
        write_register(CFG_GPU_BASE, gpu);
    endtask

    task automatic run_phase(int items, int alloc_pct);
        int sent;
        int burst;
        int pick;
        int held;
        sent = 0;
        while (sent < items) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < items; b++) begin
                pick = $urandom_range(99);
                held = pick_held_slot();
                if (pick < alloc_pct)
                    send_request(KIND_ALLOC, SLOT_W'($urandom), 1'b0, '0);
                else if (pick < 90 && held >= 0)
                    send_request(KIND_RELEASE, SLOT_W'(held), 1'b0, '0);
                else if (queued != 0 && $urandom_range(1) == 1)
                    // release a slot that already sits in the recycle queue
                    send_request(KIND_RELEASE,
                                 recycle_q[(rd_pos + $urandom_range(queued - 1)) % MAX_SLOTS],
                                 1'b0, '0);
                else
                    send_request(KIND_RELEASE, SLOT_W'($urandom), 1'b0, '0);
                sent++;
            end
            if ($urandom_range(24) == 0)
                wait_drained();
            else
                idle_gap(($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6));
        end
    endtask

    // Result sink: stall behavior switches among random modes on a random timer
    int stall_mode  = 0;
    int stall_left  = 0;
    int mode_timer  = 0;

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            case (stall_mode)
                1: if ($urandom_range(3) == 0) stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(15) == 0) stall_left = $urandom_range(5, 20);
                default: ;
            endcase
        end
        if (mode_timer == 0) begin
            stall_mode = $urandom_range(2);
            mode_timer = $urandom_range(50, 300);
        end else begin
            mode_timer--;
        end
    end

    always @(posedge aclk) begin : check_results
        slot_result_t oldest;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: status %0d slot %0d",
                       m_status, m_granted_slot);
                mismatches++;
            end else begin
                oldest = pending_results.pop_front();
                if (m_status !== oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, m_status);
                    mismatches++;
                end
                if (m_granted_slot !== oldest.slot) begin
                    $error("granted_slot: expected %0d, got %0d", oldest.slot, m_granted_slot);
                    mismatches++;
                end
                if (m_cpu_address !== oldest.cpu) begin
                    $error("cpu_address: expected %h, got %h", oldest.cpu, m_cpu_address);
                    mismatches++;
                end
                if (m_gpu_address !== oldest.gpu) begin
                    $error("gpu_address: expected %h, got %h", oldest.gpu, m_gpu_address);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        stim_row_t         row;
        logic [ADDR_W-1:0] ones;
        ones = '1;

        // reset settings: capacity 1024, stride 32, bases zero
        add_typed(KIND_ALLOC, 0, STATUS_OK, 0, 0, 0);
        add_typed(KIND_ALLOC, 0, STATUS_OK, 1, 32, 32);
        add_typed(KIND_RELEASE, 0, STATUS_OK, 0, 0, 0);
        add_typed(KIND_RELEASE, 0, STATUS_NOT_HELD, 0, 0, 0);
        add_typed(KIND_RELEASE, 1023, STATUS_NOT_HELD, 1023, 0, 0);
        add_typed(KIND_RELEASE, 512, STATUS_NOT_HELD, 512, 0, 0);
        add_typed(KIND_ALLOC, 0, STATUS_OK, 2, 64, 64);
        // shrink to the fresh counter: only recycled slots remain
        add_write(CFG_CAPACITY, 3);
        add_write(CFG_STRIDE, 256);
        add_write(CFG_CPU_BASE, 64'hFFFF_FFFF_FFFF_FF00);
        add_write(CFG_GPU_BASE, 64'h0000_0001_0000_0000);
        add_typed(KIND_ALLOC, 0, STATUS_OK, 0, 64'hFFFF_FFFF_FFFF_FF00, 64'h0000_0001_0000_0000);
        add_typed(KIND_ALLOC, 0, STATUS_EMPTY, 0, 0, 0);
        add_typed(KIND_RELEASE, 2, STATUS_OK, 2, 0, 0);
        // CPU address wraps past 2^64
        add_typed(KIND_ALLOC, 0, STATUS_OK, 2, 64'h100, 64'h0000_0001_0000_0200);
        add_write(CFG_STRIDE, 0);
        add_write(CFG_CAPACITY, 0);
        add_typed(KIND_RELEASE, 1, STATUS_OK, 1, 0, 0);
        add_typed(KIND_ALLOC, 0, STATUS_OK, 1, 64'hFFFF_FFFF_FFFF_FF00, 64'h0000_0001_0000_0000);
        add_typed(KIND_ALLOC, 0, STATUS_EMPTY, 0, 0, 0);
        // capacity above the built size saturates
        add_write(CFG_CAPACITY, 2047);
        add_write(CFG_STRIDE, 511);
        add_write(CFG_CPU_BASE, 0);
        add_write(CFG_GPU_BASE, ones);
        add_typed(KIND_ALLOC, 0, STATUS_OK, 3, 64'h5FD, 64'h5FC);
        add_request(KIND_ALLOC, 1023);
        add_request(KIND_RELEASE, 3);
        add_request(KIND_RELEASE, 0);
        add_request(KIND_ALLOC, 0);
        add_request(KIND_RELEASE, 2);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            row = script[i];
            if (row.op == ROW_WRITE)
                write_register(row.reg_idx, row.reg_data);
            else
                send_request(row.kind, row.slot, row.typed, row.want);
        end

        write_phase(1, 1, '0, ones);
        run_phase(80, 50);
        write_phase(2, 256, {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(80, 50);
        write_phase(CAP_W'($urandom_range(3, 12)), STRIDE_W'($urandom_range(1, 256)),
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(80, 55);
        write_phase(0, STRIDE_W'($urandom_range(1, 256)), ones, '0);
        run_phase(80, 45);
        write_phase(CAP_W'($urandom_range(1, 16)), STRIDE_W'($urandom_range(1, 256)),
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(80, 50);
        // full table, allocate-heavy: pushes the fresh counter well past 512
        write_phase(1024, STRIDE_W'($urandom_range(1, 256)),
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(600, 88);
        write_phase(CAP_W'($urandom_range(1, 600)), STRIDE_W'($urandom_range(1, 256)),
                    {$urandom, $urandom}, {$urandom, $urandom});
        run_phase(150, 50);

        wait_drained();
        repeat (20) @(posedge aclk);

        $display("Run covered %0d requests: %0d grants, %0d out-of-slot, %0d releases, %0d bad releases",
                 grants + exhausted + releases + rejected, grants, exhausted, releases, rejected);
        $display("over %0d register writes; fresh counter ended at %0d", reg_writes, fresh_ptr);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
